### rtl/core/pd_pkg.sv
// pd_pkg: shared types, constants and the step micro-program of the
// particle drag Euler step block. No dependencies.
package pd_pkg;

  // Q16.16 widths
  localparam int WORD_W   = 32;
  localparam int UWORD_W  = 31;
  localparam int CFG_IDX_W = 3;

  // 0.5 * air density * pi in raw Q16.16
  localparam logic [WORD_W-1:0] DRAG_GAIN = 32'd126106;

  // register reset values
  localparam logic [UWORD_W-1:0] DRAG_RST   = 31'd31457;
  localparam logic [UWORD_W-1:0] MASS_RST   = 31'd65536;
  localparam logic [UWORD_W-1:0] RADIUS_RST = 31'd6554;
  localparam logic signed [WORD_W-1:0] GRAV_X_RST = 32'sd0;
  localparam logic signed [WORD_W-1:0] GRAV_Y_RST = -32'sd642908;
  localparam logic signed [WORD_W-1:0] GRAV_Z_RST = 32'sd0;

  localparam logic signed [WORD_W-1:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] SMIN = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRAG   = 3'd0,
    CFG_MASS   = 3'd1,
    CFG_RADIUS = 3'd2,
    CFG_GRAV_X = 3'd3,
    CFG_GRAV_Y = 3'd4,
    CFG_GRAV_Z = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_STEP     = 2'd0,
    OP_LOAD_POS = 2'd1,
    OP_LOAD_VEL = 2'd2,
    OP_LOAD_IMP = 2'd3
  } op_t;

  // micro-operations; names ending in M load the shared multiplier
  typedef enum logic [4:0] {
    U_NOP, U_R2M, U_KC1M, U_KC2M, U_FD1M, U_FD2M, U_FW1M, U_FW2M,
    U_T, U_KC, U_FDRAG, U_FWIND,
    U_DNUMM, U_DSTART, U_WINDM, U_WSAVE, U_FSUM,
    U_ASTART, U_ACC, U_VELM, U_VEL, U_POSM, U_POS,
    U_SQCLR, U_SQM, U_SQACC, U_SQSTART, U_SPEED, U_DONE
  } uop_t;

  typedef struct packed {
    logic       take;   // input word accepted this cycle
    uop_t       uop;
    logic [1:0] ax;     // axis the micro-op works on
  } cmd_t;

  typedef struct packed {
    logic unit_done;    // divider or square root finished
  } stat_t;

  // program entry points
  localparam int PC_W     = 6;
  localparam int PC_COEF  = 0;
  localparam int PC_FORCE = 14;
  localparam int PC_INTEG = 29;
  localparam int PC_LEN   = 47;
  localparam int PC_DONE  = 56;

  function automatic logic is_start(uop_t u);
    return (u == U_DSTART) || (u == U_ASTART) || (u == U_SQSTART);
  endfunction

  function automatic logic [WORD_W-1:0] mag32(logic signed [WORD_W-1:0] a);
    return a[WORD_W-1] ? (~a + 32'd1) : a;
  endfunction

  // saturate a 51-bit signed sum to 32 bits
  function automatic logic signed [WORD_W-1:0] sat32(logic signed [50:0] x);
    logic hi_same;
    hi_same = (x[50:31] == '0) || (x[50:31] == '1);
    if (hi_same) return x[31:0];
    return x[50] ? SMIN : SMAX;
  endfunction

  // step micro-program
  function automatic cmd_t prog(logic [PC_W-1:0] pc);
    cmd_t c;
    logic [PC_W-1:0] off;
    c.take = 1'b0;
    c.uop  = U_NOP;
    c.ax   = 2'd0;
    off    = '0;
    if (pc < PC_W'(PC_FORCE)) begin
      case (pc)
        6'd0:  c.uop = U_R2M;
        6'd1:  c.uop = U_T;
        6'd2:  c.uop = U_KC1M;
        6'd3:  c.uop = U_T;
        6'd4:  c.uop = U_KC2M;
        6'd5:  c.uop = U_KC;
        6'd6:  c.uop = U_FD1M;
        6'd7:  c.uop = U_T;
        6'd8:  c.uop = U_FD2M;
        6'd9:  c.uop = U_FDRAG;
        6'd10: c.uop = U_FW1M;
        6'd11: c.uop = U_T;
        6'd12: c.uop = U_FW2M;
        6'd13: c.uop = U_FWIND;
        default: c.uop = U_NOP;
      endcase
    end else if (pc < PC_W'(PC_INTEG)) begin
      // five micro-ops per axis
      if (pc < 6'd19) begin
        c.ax = 2'd0; off = pc - 6'd14;
      end else if (pc < 6'd24) begin
        c.ax = 2'd1; off = pc - 6'd19;
      end else begin
        c.ax = 2'd2; off = pc - 6'd24;
      end
      case (off)
        6'd0: c.uop = U_DNUMM;
        6'd1: c.uop = U_DSTART;
        6'd2: c.uop = U_WINDM;
        6'd3: c.uop = U_WSAVE;
        6'd4: c.uop = U_FSUM;
        default: c.uop = U_NOP;
      endcase
    end else if (pc < PC_W'(PC_LEN)) begin
      // six micro-ops per axis
      if (pc < 6'd35) begin
        c.ax = 2'd0; off = pc - 6'd29;
      end else if (pc < 6'd41) begin
        c.ax = 2'd1; off = pc - 6'd35;
      end else begin
        c.ax = 2'd2; off = pc - 6'd41;
      end
      case (off)
        6'd0: c.uop = U_ASTART;
        6'd1: c.uop = U_ACC;
        6'd2: c.uop = U_VELM;
        6'd3: c.uop = U_VEL;
        6'd4: c.uop = U_POSM;
        6'd5: c.uop = U_POS;
        default: c.uop = U_NOP;
      endcase
    end else begin
      case (pc)
        6'd47: c.uop = U_SQCLR;
        6'd48: begin c.uop = U_SQM;   c.ax = 2'd0; end
        6'd49: begin c.uop = U_SQACC; c.ax = 2'd0; end
        6'd50: begin c.uop = U_SQM;   c.ax = 2'd1; end
        6'd51: begin c.uop = U_SQACC; c.ax = 2'd1; end
        6'd52: begin c.uop = U_SQM;   c.ax = 2'd2; end
        6'd53: begin c.uop = U_SQACC; c.ax = 2'd2; end
        6'd54: c.uop = U_SQSTART;
        6'd55: c.uop = U_SPEED;
        6'd56: c.uop = U_DONE;
        default: c.uop = U_NOP;
      endcase
    end
    return c;
  endfunction

endpackage

### rtl/core/pd_if.sv
// pd_if: valid/ready channel interfaces for the input and result words.
// Depends on nothing.
interface pd_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [30:0]        time_step;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic [30:0]        wind_mag;
  logic               collided;

  modport source (output valid, op, time_step, vec_x, vec_y, vec_z, wind_mag, collided,
                  input ready);
  modport sink (input valid, op, time_step, vec_x, vec_y, vec_z, wind_mag, collided,
                output ready);
endinterface

interface pd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic [30:0]        speed_out;

  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, speed_out,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, speed_out,
                output ready);
endinterface

### rtl/core/particle_drag_euler_step.sv
// particle_drag_euler_step: top level, joins controller and datapath.
// Depends on pd_pkg, pd_if, pd_ctrl, pd_dp.
//
// One particle in Q16.16. The in_ch channel takes one word at a time: a step
// (forces, or the impact force on a collision, then one Euler update) or a
// load of position, velocity or impact force. Every word gives exactly one
// result word on out_ch: position, velocity and speed after it. Registers are
// written through cfg_we, cfg_idx and cfg_data; the user must write them only
// while the block is idle, as the block itself does not enforce it; indexes
// above 5 are ignored. A load of position or impact force goes straight to
// the result; a load of velocity runs 10 micro-ops plus the square root; a
// step with collision runs three divides and the square root, one without
// collision six divides and the square root. The divider makes two quotient
// bits a cycle, the root one bit a cycle.
// One word is in work at a time; in_ch.ready is high only when idle, and
// the next word can be taken in the cycle after the result is taken. The
// result is held on out_ch until taken; a stalled receiver holds the block.
// Reset clears the state to zero and loads the register defaults.
module particle_drag_euler_step import pd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  pd_in_if.sink                in_ch,
  pd_out_if.source             out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [WORD_W-1:0]    cfg_data
);

  cmd_t                     cmd;
  stat_t                    stat;
  logic signed [WORD_W-1:0] in_vec [3];
  logic signed [WORD_W-1:0] res_pos [3];
  logic signed [WORD_W-1:0] res_vel [3];
  logic [UWORD_W-1:0]       res_speed;

  assign in_vec[0] = in_ch.vec_x;
  assign in_vec[1] = in_ch.vec_y;
  assign in_vec[2] = in_ch.vec_z;

  pd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_hit    (in_ch.collided),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  pd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_op     (in_ch.op),
    .in_dt     (in_ch.time_step),
    .in_vec    (in_vec),
    .in_ws     (in_ch.wind_mag),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .res_pos   (res_pos),
    .res_vel   (res_vel),
    .res_speed (res_speed)
  );

  // result word
  assign out_ch.pos_x     = res_pos[0];
  assign out_ch.pos_y     = res_pos[1];
  assign out_ch.pos_z     = res_pos[2];
  assign out_ch.vel_x     = res_vel[0];
  assign out_ch.vel_y     = res_vel[1];
  assign out_ch.vel_z     = res_vel[2];
  assign out_ch.speed_out = res_speed;

endmodule

### rtl/core/pd_div.sv
// pd_div: 64/32 unsigned restoring divider, two quotient bits a cycle.
// Depends on nothing; used by pd_dp.
module pd_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [63:0] quo
);

  logic [63:0] nq_r, nq_nxt;   // numerator out at the top, quotient in at the bottom
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] den_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;

  // two restoring steps
  always_comb begin
    logic [32:0] t;
    rem_nxt = rem_r;
    nq_nxt  = nq_r;
    for (int s = 0; s < 2; s++) begin
      t = {rem_nxt, nq_nxt[63]};
      nq_nxt = {nq_nxt[62:0], 1'b0};
      if (t >= {1'b0, den_r}) begin
        t = t - {1'b0, den_r};
        nq_nxt[0] = 1'b1;
      end
      rem_nxt = t[31:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 5'd31);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r  <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) busy_r <= 1'b0;
      end
    end
  end

  // operands
  always_ff @(posedge clk) begin
    if (start) begin
      nq_r  <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      nq_r  <= nq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = nq_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("divider restarted while busy");

endmodule

### rtl/core/pd_sqrt.sv
// pd_sqrt: floor square root of a 64-bit value, one result bit a cycle.
// Depends on nothing; used by pd_dp.
module pd_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] x,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rem_r, rem_nxt;
  logic [63:0] res_r, res_nxt;
  logic [4:0]  k_r;            // trial bit is 4^k
  logic        busy_r;
  logic        done_r;

  // one step of the digit-by-digit root
  always_comb begin
    logic [63:0] b;
    logic [63:0] trial;
    b     = 64'd1 << {k_r, 1'b0};
    trial = res_r + b;
    if (rem_r >= trial) begin
      rem_nxt = rem_r - trial;
      res_nxt = (res_r >> 1) + b;
    end else begin
      rem_nxt = rem_r;
      res_nxt = res_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= busy_r && (k_r == 5'd0);
      if (start) begin
        busy_r <= 1'b1;
        k_r    <= 5'd31;
      end else if (busy_r) begin
        k_r <= k_r - 5'd1;
        if (k_r == 5'd0) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= x;
      res_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      res_r <= res_nxt;
    end
  end

  assign done = done_r;
  assign root = res_r[31:0];

endmodule

### rtl/core/pd_dp.sv
// pd_dp: datapath - particle state, registers, shared 32x32 multiplier,
// divider and square root. Depends on pd_pkg, pd_div, pd_sqrt.
module pd_dp import pd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmd_t                      cmd,
  output stat_t                     stat,
  input  logic [1:0]                in_op,
  input  logic [UWORD_W-1:0]        in_dt,
  input  logic signed [WORD_W-1:0]  in_vec [3],
  input  logic [UWORD_W-1:0]        in_ws,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_idx,
  input  logic [WORD_W-1:0]         cfg_data,
  output logic signed [WORD_W-1:0]  res_pos [3],
  output logic signed [WORD_W-1:0]  res_vel [3],
  output logic [UWORD_W-1:0]        res_speed
);

  // configuration
  logic [UWORD_W-1:0]       drag_r, mass_r, rad_r;
  logic signed [WORD_W-1:0] grav_r [3];

  // particle state
  logic signed [WORD_W-1:0] pos_r [3];
  logic signed [WORD_W-1:0] vel_r [3];
  logic signed [WORD_W-1:0] imp_r [3];
  logic signed [WORD_W-1:0] force_r [3];
  logic [WORD_W-1:0]        speed_r;

  // latched step word
  logic [UWORD_W-1:0]       dt_r, ws_r;
  logic signed [WORD_W-1:0] wvec_r [3];

  // temporaries
  logic [63:0]              prod_r;
  logic                     sgn_r;
  logic [WORD_W-1:0]        t_r, kc_r, fdrag_r, fwind_r;
  logic signed [48:0]       wind_r;
  logic signed [WORD_W-1:0] acc_r;
  logic [63:0]              sumsq_r;

  logic [WORD_W-1:0]        ma, mb;
  logic                     ms;
  logic [WORD_W-1:0]        usat;
  logic signed [48:0]       sval;
  logic                     div_start, div_done, sq_start, sq_done;
  logic [63:0]              div_num, quo;
  logic [31:0]              div_den, root;
  logic signed [50:0]       dterm, fsum, vsum, psum;
  logic signed [WORD_W-1:0] acc_val;

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    ms = 1'b0;
    case (cmd.uop)
      U_R2M:  begin ma = {1'b0, rad_r}; mb = {1'b0, rad_r}; end
      U_KC1M: begin ma = DRAG_GAIN;     mb = t_r; end
      U_KC2M: begin ma = t_r;           mb = {1'b0, drag_r}; end
      U_FD1M: begin ma = kc_r;          mb = speed_r; end
      U_FD2M: begin ma = t_r;           mb = speed_r; end
      U_FW1M: begin ma = kc_r;          mb = {1'b0, ws_r}; end
      U_FW2M: begin ma = t_r;           mb = {1'b0, ws_r}; end
      U_DNUMM: begin ma = mag32(vel_r[cmd.ax]); mb = fdrag_r; end
      U_WINDM: begin
        ma = mag32(wvec_r[cmd.ax]); mb = fwind_r; ms = wvec_r[cmd.ax][31];
      end
      U_VELM: begin ma = mag32(acc_r); mb = {1'b0, dt_r}; ms = acc_r[31]; end
      U_POSM: begin
        ma = mag32(vel_r[cmd.ax]); mb = {1'b0, dt_r}; ms = vel_r[cmd.ax][31];
      end
      U_SQM:  begin ma = mag32(vel_r[cmd.ax]); mb = mag32(vel_r[cmd.ax]); end
      default: begin ma = '0; mb = '0; ms = 1'b0; end
    endcase
  end

  // product forms: unsigned saturated, and signed truncated toward zero
  assign usat = (prod_r[63:48] != '0) ? '1 : prod_r[47:16];
  assign sval = sgn_r ? -$signed({1'b0, prod_r[63:16]}) : $signed({1'b0, prod_r[63:16]});

  // force sum for one axis: gravity, drag against velocity, wind
  always_comb begin
    if (speed_r == '0) begin
      dterm = '0;
    end else if (vel_r[cmd.ax][31]) begin
      dterm = $signed({18'b0, quo[32:0]});
    end else begin
      dterm = -$signed({18'b0, quo[32:0]});
    end
    fsum = $signed({{19{grav_r[cmd.ax][31]}}, grav_r[cmd.ax]}) + dterm
         + $signed({{2{wind_r[48]}}, wind_r});
  end

  // acceleration from the mass quotient
  always_comb begin
    if (quo[63:31] != '0) begin
      acc_val = force_r[cmd.ax][31] ? SMIN : SMAX;
    end else if (force_r[cmd.ax][31]) begin
      acc_val = -$signed(quo[31:0]);
    end else begin
      acc_val = $signed(quo[31:0]);
    end
  end

  assign vsum = $signed({{19{vel_r[cmd.ax][31]}}, vel_r[cmd.ax]})
              + $signed({{2{sval[48]}}, sval});
  assign psum = $signed({{19{pos_r[cmd.ax][31]}}, pos_r[cmd.ax]})
              + $signed({{2{sval[48]}}, sval});

  // divider operands: drag direction or mass division
  assign div_start = (cmd.uop == U_DSTART) || (cmd.uop == U_ASTART);
  always_comb begin
    if (cmd.uop == U_ASTART) begin
      div_num = {16'b0, mag32(force_r[cmd.ax]), 16'b0};
      div_den = (mass_r == '0) ? 32'd1 : {1'b0, mass_r};
    end else begin
      div_num = prod_r;
      div_den = speed_r;
    end
  end
  assign sq_start = (cmd.uop == U_SQSTART);

  pd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  pd_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .x     (sumsq_r),
    .done  (sq_done),
    .root  (root)
  );

  assign stat.unit_done = div_done | sq_done;

  // multiplier output register and temporaries
  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    sgn_r  <= ms;
    case (cmd.uop)
      U_T:     t_r     <= usat;
      U_KC:    kc_r    <= usat;
      U_FDRAG: fdrag_r <= usat;
      U_FWIND: fwind_r <= usat;
      U_WSAVE: wind_r  <= sval;
      U_ACC:   acc_r   <= acc_val;
      U_SQCLR: sumsq_r <= '0;
      U_SQACC: sumsq_r <= sumsq_r + prod_r;
      default: ;
    endcase
    if (cmd.take) begin
      dt_r <= in_dt;
      ws_r <= in_ws;
      for (int i = 0; i < 3; i++) wvec_r[i] <= in_vec[i];
    end
  end

  // architectural state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drag_r    <= DRAG_RST;
      mass_r    <= MASS_RST;
      rad_r     <= RADIUS_RST;
      grav_r[0] <= GRAV_X_RST;
      grav_r[1] <= GRAV_Y_RST;
      grav_r[2] <= GRAV_Z_RST;
      speed_r   <= '0;
      for (int i = 0; i < 3; i++) begin
        pos_r[i]   <= '0;
        vel_r[i]   <= '0;
        imp_r[i]   <= '0;
        force_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_DRAG:   drag_r    <= cfg_data[UWORD_W-1:0];
          CFG_MASS:   mass_r    <= cfg_data[UWORD_W-1:0];
          CFG_RADIUS: rad_r     <= cfg_data[UWORD_W-1:0];
          CFG_GRAV_X: grav_r[0] <= cfg_data;
          CFG_GRAV_Y: grav_r[1] <= cfg_data;
          CFG_GRAV_Z: grav_r[2] <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.take) begin
        // collision forces come straight from the impact vector
        for (int i = 0; i < 3; i++) force_r[i] <= imp_r[i];
        case (in_op)
          OP_LOAD_POS: for (int i = 0; i < 3; i++) pos_r[i] <= in_vec[i];
          OP_LOAD_VEL: for (int i = 0; i < 3; i++) vel_r[i] <= in_vec[i];
          OP_LOAD_IMP: for (int i = 0; i < 3; i++) imp_r[i] <= in_vec[i];
          default: ;
        endcase
      end
      case (cmd.uop)
        U_FSUM:  force_r[cmd.ax] <= sat32(fsum);
        U_VEL:   vel_r[cmd.ax]   <= sat32(vsum);
        U_POS:   pos_r[cmd.ax]   <= sat32(psum);
        U_SPEED: speed_r         <= root;
        default: ;
      endcase
    end
  end

  assign res_pos   = pos_r;
  assign res_vel   = vel_r;
  assign res_speed = speed_r[31] ? '1 : speed_r[30:0];

endmodule

### rtl/core/pd_ctrl.sv
// pd_ctrl: controller - handshakes and the micro-program sequencer.
// Depends on pd_pkg.
module pd_ctrl import pd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  input  logic       in_hit,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output cmd_t       cmd,
  input  stat_t      stat
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_WAIT = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            take;
  cmd_t            pcmd;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_RESP);
  assign take      = in_valid && in_ready;
  assign pcmd      = prog(pc_r);

  // command to the datapath
  always_comb begin
    cmd      = pcmd;
    cmd.take = take;
    if (state_r != S_EXEC) begin
      cmd.uop = U_NOP;
      cmd.ax  = 2'd0;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          case (in_op)
            OP_STEP: begin
              state_nxt = S_EXEC;
              pc_nxt    = in_hit ? PC_W'(PC_INTEG) : PC_W'(PC_COEF);
            end
            OP_LOAD_VEL: begin
              state_nxt = S_EXEC;
              pc_nxt    = PC_W'(PC_LEN);
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end
      S_EXEC: begin
        if (pcmd.uop == U_DONE) begin
          state_nxt = S_RESP;
        end else begin
          pc_nxt = pc_r + PC_W'(1);
          if (is_start(pcmd.uop)) state_nxt = S_WAIT;
        end
      end
      S_WAIT: if (stat.unit_done) state_nxt = S_EXEC;
      S_RESP: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    stat.unit_done |-> state_r == S_WAIT)
    else $error("unit finished outside a wait");

  a_start_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && is_start(pcmd.uop)) |=> state_r == S_WAIT)
    else $error("unit started without waiting");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |-> pc_r <= PC_W'(PC_DONE))
    else $error("program counter past end");

endmodule
